/* design/dcs_pkg.sv */
// Package for the descending count sorter.
// Holds default sizes, the item type and the input queue depth; no dependencies.
package dcs_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int QDEPTH       = 4;
    localparam int QPW          = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0]  symbol;
        logic [31:0] count;
        logic        last;
    } item_t;
endpackage

/* design/dcs_front.sv */
// Front end of the descending count sorter: accepts requests into a short queue.
// Depends on dcs_pkg.
module dcs_front
    import dcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  symbol,
    input  logic [31:0] count,
    input  logic        last,
    output logic        deq_valid,
    input  logic        deq_ready,
    output item_t       deq_item
);
    item_t            q_reg [QDEPTH];
    logic [QPW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [QPW:0]     cnt_reg, cnt_next;
    logic             enq, deq;

    assign full      = (cnt_reg == (QPW+1)'(QDEPTH));
    assign deq_valid = (cnt_reg != '0);
    assign deq_item  = q_reg[rd_reg];
    assign enq       = push && !full;
    assign deq       = deq_valid && deq_ready;

    always_comb
    begin
        wr_next  = enq ? wr_reg + 1'b1 : wr_reg;
        rd_next  = deq ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPW+1)'(enq) - (QPW+1)'(deq);
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_reg] <= '{symbol: symbol, count: count, last: last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

/* design/dcs_back.sv */
// Back end of the descending count sorter: stores the set, sorts it with a
// stack-driven Lomuto partition sequencer and emits the results. Depends on dcs_pkg.
module dcs_back
    import dcs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        deq_valid,
    output logic        deq_ready,
    input  item_t       deq_item,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_symbol,
    output logic [31:0] out_count,
    output logic        out_last,
    output logic        overflow
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int EW = 8 + KEY_BITS;

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_POP   = 4'd2;
    localparam logic [3:0] ST_POPW  = 4'd3;
    localparam logic [3:0] ST_PIV   = 4'd4;
    localparam logic [3:0] ST_SCAN  = 4'd5;
    localparam logic [3:0] ST_CMP   = 4'd6;
    localparam logic [3:0] ST_SWP   = 4'd7;
    localparam logic [3:0] ST_PSH1  = 4'd8;
    localparam logic [3:0] ST_PSH2  = 4'd9;
    localparam logic [3:0] ST_ERD   = 4'd10;
    localparam logic [3:0] ST_ELD   = 4'd11;

    logic [EW-1:0]   mem [CAPACITY];
    logic [2*FW-1:0] stk [CAPACITY];

    logic [3:0]      state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            drop_reg, drop_next;
    logic [FW-1:0]   depth_reg, depth_next;
    logic [FW-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [FW-1:0]   i_reg, i_next, slot_reg, slot_next;
    logic [KEY_BITS-1:0] piv_reg, piv_next;
    logic [EW-1:0]   tmp_reg, tmp_next;
    logic            ov_reg, ov_next;
    logic [7:0]      osym_reg, osym_next;
    logic [31:0]     ocnt_reg, ocnt_next;
    logic            olast_reg, olast_next, oovf_reg, oovf_next;

    logic [AW-1:0]   a0, a1, wa, sa;
    logic [EW-1:0]   rd0, rd1, wd;
    logic            we;
    logic [2*FW-1:0] srd, swd;
    logic [AW-1:0]   swa;
    logic            swe;
    logic [KEY_BITS+31:0] kin_wide;
    logic [KEY_BITS+31:0] kout_wide;
    logic [FW-1:0]   pl, ph;

    assign kin_wide   = {{KEY_BITS{1'b0}}, deq_item.count};
    assign kout_wide  = {32'd0, rd0[KEY_BITS-1:0]};
    assign deq_ready  = (state_reg == ST_LOAD);
    assign empty      = !ov_reg;
    assign out_symbol = osym_reg;
    assign out_count  = ocnt_reg;
    assign out_last   = olast_reg;
    assign overflow   = oovf_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        drop_next  = drop_reg;
        depth_next = depth_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        slot_next  = slot_reg;
        piv_next   = piv_reg;
        tmp_next   = tmp_reg;
        ov_next    = ov_reg;
        osym_next  = osym_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;
        oovf_next  = oovf_reg;
        a0  = i_reg[AW-1:0];
        a1  = slot_reg[AW-1:0];
        we  = 1'b0;
        wa  = fill_reg[AW-1:0];
        wd  = {deq_item.symbol, kin_wide[KEY_BITS-1:0]};
        sa  = AW'(depth_reg - 1'b1);
        swe = 1'b0;
        swa = depth_reg[AW-1:0];
        pl  = slot_reg;
        ph  = hi_reg;
        swd = {pl, ph};
        if (ov_reg && pop)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_LOAD:
            begin
                if (deq_valid)
                begin
                    if (fill_reg < FW'(CAPACITY))
                    begin
                        we        = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (deq_item.last)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                pl  = '0;
                ph  = fill_reg;
                swd = {pl, ph};
                swa = '0;
                depth_next = '0;
                if (ph > pl + 1'b1)
                begin
                    swe        = 1'b1;
                    depth_next = FW'(1);
                end
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (depth_reg == '0)
                begin
                    i_next     = '0;
                    state_next = ST_ERD;
                end
                else
                begin
                    depth_next = depth_reg - 1'b1;
                    state_next = ST_POPW;
                end
            end
            ST_POPW:
            begin
                lo_next    = srd[2*FW-1:FW];
                hi_next    = srd[FW-1:0];
                a0         = AW'(srd[FW-1:0] - 1'b1);
                state_next = ST_PIV;
            end
            ST_PIV:
            begin
                piv_next   = rd0[KEY_BITS-1:0];
                i_next     = lo_reg;
                slot_next  = lo_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                state_next = (i_reg == hi_reg) ? ST_PSH1 : ST_CMP;
            end
            ST_CMP:
            begin
                if (rd0[KEY_BITS-1:0] >= piv_reg)
                begin
                    if (slot_reg < i_reg)
                    begin
                        we         = 1'b1;
                        wa         = slot_reg[AW-1:0];
                        wd         = rd0;
                        tmp_next   = rd1;
                        state_next = ST_SWP;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SWP:
            begin
                we         = 1'b1;
                wa         = i_reg[AW-1:0];
                wd         = tmp_reg;
                slot_next  = slot_reg + 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = ST_SCAN;
            end
            ST_PSH1, ST_PSH2:
            begin
                if (state_reg == ST_PSH1)
                begin
                    pl = slot_reg;
                    ph = hi_reg;
                    state_next = ST_PSH2;
                end
                else
                begin
                    pl = lo_reg;
                    ph = slot_reg - 1'b1;
                    state_next = ST_POP;
                end
                swd = {pl, ph};
                if (ph > pl + 1'b1 && depth_reg < FW'(CAPACITY))
                begin
                    swe        = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
            ST_ERD:
            begin
                state_next = ST_ELD;
            end
            ST_ELD:
            begin
                if (!ov_reg || pop)
                begin
                    ov_next    = 1'b1;
                    osym_next  = rd0[EW-1:KEY_BITS];
                    ocnt_next  = kout_wide[31:0];
                    olast_next = (i_reg == fill_reg - 1'b1);
                    oovf_next  = drop_reg;
                    i_next     = i_reg + 1'b1;
                    if (i_reg == fill_reg - 1'b1)
                    begin
                        fill_next  = '0;
                        drop_next  = 1'b0;
                        depth_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd0 <= mem[a0];
        rd1 <= mem[a1];
        if (swe)
        begin
            stk[swa] <= swd;
        end
        srd <= stk[sa];
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        slot_reg  <= slot_next;
        piv_reg   <= piv_next;
        tmp_reg   <= tmp_next;
        osym_reg  <= osym_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
        oovf_reg  <= oovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            drop_reg  <= 1'b0;
            depth_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
            depth_reg <= depth_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

/* design/descending_count_sorter_unit.sv */
// Top level of the descending count sorter: input queue plus sort engine.
// Depends on dcs_pkg, dcs_front and dcs_back.
//
// Usage: push (symbol, count, last) requests while full is low; each is taken
// into a four-entry queue. While loading a set, the engine takes one request
// per cycle into its store of CAPACITY entries. A request with last set closes
// the set; requests beyond CAPACITY are dropped and flag overflow on every
// result of that set. The engine then sorts by count, largest first, with a
// Lomuto partition sequencer over a range stack: per range it pops the bounds,
// reads the pivot, scans and compares each element, swaps where needed and
// pushes the subranges left to sort; it is slowest when counts tie or arrive
// already ordered. Results come out one at a time: empty low shows the oldest
// result, pop takes it; out_last marks the end of the run. While the receiver
// stalls, the result register holds and the engine waits; the input queue
// keeps taking requests until it fills. Reset empties queue and store at once.
module descending_count_sorter_unit
    import dcs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  symbol,
    input  logic [31:0] count,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_symbol,
    output logic [31:0] out_count,
    output logic        out_last,
    output logic        overflow
);
    logic  deq_valid, deq_ready;
    item_t deq_item;

    dcs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .symbol    (symbol),
        .count     (count),
        .last      (last),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_item  (deq_item)
    );

    dcs_back #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .deq_valid  (deq_valid),
        .deq_ready  (deq_ready),
        .deq_item   (deq_item),
        .empty      (empty),
        .pop        (pop),
        .out_symbol (out_symbol),
        .out_count  (out_count),
        .out_last   (out_last),
        .overflow   (overflow)
    );

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result visible right after reset");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_symbol) && $stable(out_count)
                              && $stable(out_last) && $stable(overflow)))
        else $error("result changed while the receiver stalls");
`endif
endmodule
